// ===== sv/waypoint_heading_follower_defines.svh =====
// assertion macros for the waypoint heading follower
`ifndef WAYPOINT_HEADING_FOLLOWER_DEFINES_SVH
`define WAYPOINT_HEADING_FOLLOWER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define WHF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WHF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/whf_pkg.sv =====
// package: constants, types and the arctangent table of the follower
`default_nettype none
package whf_pkg;
  localparam int MAX_WAYPOINTS_DEF = 256;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_OBSTACLE = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_SPARE    = 2'd3;

  localparam logic [1:0] KIND_DRIVE    = 2'd0;
  localparam logic [1:0] KIND_OBSTACLE = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;

  localparam logic [2:0] REG_GAIN   = 3'd0;
  localparam logic [2:0] REG_LIN    = 3'd1;
  localparam logic [2:0] REG_ANG    = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_TURN   = 3'd4;

  localparam logic signed [31:0] HALF_PI_Z = 32'sd843314857;
  localparam logic signed [31:0] PI_Z      = 32'sd1686629713;
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_SQX, ST_SQY, ST_PRE, ST_ITER,
    ST_WRAP, ST_MUL, ST_SAT, ST_OUT
  } state_t;

  // control from sequencer to cordic unit
  typedef struct packed {
    logic start;
    logic step;
  } cordic_ctl_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd421657428;  5'd1: r = 32'sd248918915;
      5'd2: r = 32'sd131521918;  5'd3: r = 32'sd66762579;
      5'd4: r = 32'sd33510843;   5'd5: r = 32'sd16771758;
      5'd6: r = 32'sd8387925;    5'd7: r = 32'sd4194219;
      5'd8: r = 32'sd2097141;    5'd9: r = 32'sd1048575;
      default: r = 32'sd524288 >>> (i - 5'd10);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/whf_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module whf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/whf_cordic.sv =====
// iterative vectoring cordic, one micro-rotation per step
`default_nettype none
module whf_cordic import whf_pkg::*; (
  input  wire logic               clk,
  input  wire cordic_ctl_t        ctl,
  input  wire logic signed [32:0] dx,
  input  wire logic signed [32:0] dy,
  output logic signed [31:0]      angle
);
  // 33-bit inputs grow by at most ~1.65 after rotation
  logic signed [35:0] x, y;
  logic signed [31:0] z;
  logic [4:0] i;
  logic signed [35:0] xs, ys;
  logic signed [32:0] zc;
  assign xs = x >>> i;
  assign ys = y >>> i;
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      i <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x <= 36'(dy); y <= -36'(dx); z <= HALF_PI_Z;
        end else begin
          x <= -36'(dy); y <= 36'(dx); z <= -HALF_PI_Z;
        end
      end else begin
        x <= 36'(dx); y <= 36'(dy); z <= '0;
      end
    end else if (ctl.step) begin
      i <= i + 5'd1;
      if (y >= 0) begin
        x <= x + ys; y <= y - xs; z <= z + atan_entry(i);
      end else begin
        x <= x - ys; y <= y + xs; z <= z - atan_entry(i);
      end
    end
  end
  assign zc = 33'(z);
  always_comb begin
    if (zc > 33'(PI_Z)) angle = PI_Z;
    else if (zc < -33'(PI_Z)) angle = -PI_Z;
    else angle = z;
  end
endmodule
`default_nettype wire

// ===== sv/waypoint_heading_follower.sv =====
// top level: waypoint path store, sequencer and proportional heading control
// usage:
//   s_axis carries one transaction per command: load waypoint, set obstacle
//   flag or control tick. m_axis carries at most one result per tick.
//   cfg writes a register index and value; take it only while idle.
// busy periods:
//   loads, obstacle writes, ticks with no result and stop ticks are taken
//   in ST_IDLE and can follow back to back while the receiver keeps up.
//   a tick that reaches the arrival check keeps s_axis_tready low through
//   ST_READ, ST_CHECK, ST_SQX and ST_SQY; arrival then frees the input.
//   a drive tick keeps s_axis_tready low through those states, ST_PRE, the
//   ST_ITER steps, ST_WRAP, ST_MUL, ST_SAT and ST_OUT, set by the single
//   cordic unit that runs one micro-rotation per cycle; the result is valid
//   in the next cycle and a new transaction can be taken in that same cycle
//   if the result leaves.
// reset:
//   rst (synchronous) clears the path length, index, flags and registers to
//   their defaults. path memory contents stay undefined until written.
// stall:
//   a result sits in the output register until m_axis_tready; no new input
//   is taken while it waits.
`default_nettype none
module waypoint_heading_follower import whf_pkg::*; #(
  parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: waypoint_x, waypoint_y, obstacle, pose_valid, robot_x, robot_y,
  // heading, zero pad (bits 151:146)
  input  wire logic [151:0] s_axis_tdata,
  // tuser: command [1:0]
  input  wire logic [1:0]   s_axis_tuser,
  // tlast: first_of_path
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: forward speed, turn rate, remaining
  output logic [39:0]       m_axis_tdata,
  // tuser: kind
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [19:0]  cfg_data
);
  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WAYPOINTS);
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  // configuration registers
  logic [15:0] heading_gain;
  logic [14:0] max_linear, max_angular, turn_threshold;
  logic [19:0] arrive_radius;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_gain <= 16'd4096; max_linear <= 15'd2048; max_angular <= 15'd2048;
      arrive_radius <= 20'd6554; turn_threshold <= 15'd6434;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:   heading_gain <= cfg_data[15:0];
        REG_LIN:    max_linear <= cfg_data[14:0];
        REG_ANG:    max_angular <= cfg_data[14:0];
        REG_RADIUS: arrive_radius <= cfg_data;
        REG_TURN:   turn_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [1:0] command;
  logic signed [31:0] wx_in, wy_in, rx_in, ry_in;
  logic obstacle_in, pose_valid_in;
  logic signed [15:0] yaw_in;
  assign command = s_axis_tuser;
  assign wx_in = s_axis_tdata[31:0];
  assign wy_in = s_axis_tdata[63:32];
  assign obstacle_in = s_axis_tdata[64];
  assign pose_valid_in = s_axis_tdata[65];
  assign rx_in = s_axis_tdata[97:66];
  assign ry_in = s_axis_tdata[129:98];
  assign yaw_in = s_axis_tdata[145:130];

  state_t state, state_next;
  logic [LW-1:0] path_length, target_index;
  logic path_active, obstacle_flag;
  logic signed [31:0] rx, ry;
  logic signed [15:0] yaw;
  logic signed [32:0] dx, dy;
  logic [63:0] dsq;
  logic signed [17:0] diff;
  logic signed [33:0] prod;
  logic [4:0] step_cnt;
  logic out_valid;
  logic [14:0] out_lin;
  logic signed [15:0] out_ang;
  logic [8:0] out_rem;
  logic [1:0] out_kind;

  // input taken when idle and the output register is empty or emptying
  logic accept;
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  // path memories
  logic wr_en;
  logic [LW-1:0] wr_addr;
  logic [31:0] xq, yq;
  assign wr_addr = (s_axis_tlast) ? '0 : path_length;
  assign wr_en = accept && command == CMD_LOAD && (s_axis_tlast || path_length < LEN_MAX);
  whf_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
    .clk, .we(wr_en), .waddr(wr_addr[AW-1:0]), .wdata(wx_in),
    .raddr(target_index[AW-1:0]), .rdata(xq));
  whf_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
    .clk, .we(wr_en), .waddr(wr_addr[AW-1:0]), .wdata(wy_in),
    .raddr(target_index[AW-1:0]), .rdata(yq));

  cordic_ctl_t cctl;
  logic signed [31:0] angle;
  whf_cordic u_cordic (
    .clk, .ctl(cctl), .dx, .dy, .angle);

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  assign mprod = ma * mb;
  always_comb begin
    ma = 34'(dx); mb = 34'(dx);
    case (state)
      ST_SQY: begin ma = 34'(dy); mb = 34'(dy); end
      ST_MUL: begin ma = 34'($signed({1'b0, heading_gain})); mb = 34'(diff); end
      ST_CHECK: begin ma = 34'($signed({1'b0, arrive_radius}));
                mb = 34'($signed({1'b0, arrive_radius})); end
      default: ;
    endcase
  end

  logic near;
  logic [41:0] rsq;
  logic signed [17:0] tgt;
  logic signed [31:0] ang_round;
  logic signed [17:0] adiff;
  logic sharp;
  assign near = (dx < 33'sd2097152) && (dx > -33'sd2097152)
             && (dy < 33'sd2097152) && (dy > -33'sd2097152);
  assign tgt = 18'((33'(angle) + 33'sd32768) >>> 16);
  assign adiff = diff < 0 ? -diff : diff;
  assign sharp = adiff > 18'(turn_threshold);

  // tick outcome at acceptance: completion stop, obstacle stop, full run or no action
  logic tick_done, tick_stop, tick_run, arrived, out_set;
  assign tick_done = path_active && (target_index >= path_length);
  assign tick_stop = !tick_done && path_active && pose_valid_in && obstacle_flag;
  assign tick_run = !tick_done && path_active && pose_valid_in && !obstacle_flag;
  // squared distance compare, meaningful in ST_SQY only
  assign arrived = near && ((dsq + 64'(mprod)) < 64'(rsq));
  assign out_set = (accept && command == CMD_TICK && (tick_done || tick_stop))
                || (state == ST_OUT);

  always_comb begin
    state_next = state;
    cctl = '0;
    case (state)
      ST_IDLE: if (accept && command == CMD_TICK && tick_run) state_next = ST_READ;
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: state_next = ST_SQX;
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = arrived ? ST_IDLE : ST_PRE;
      ST_PRE: begin cctl.start = 1'b1; state_next = ST_ITER; end
      ST_ITER: begin
        cctl.step = 1'b1;
        if (step_cnt == LAST_STEP) state_next = ST_WRAP;
      end
      ST_WRAP: state_next = ST_MUL;
      ST_MUL: state_next = ST_SAT;
      ST_SAT: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      path_length <= '0; target_index <= '0;
      path_active <= 1'b0; obstacle_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      if (accept) begin
        case (command)
          CMD_LOAD: begin
            if (s_axis_tlast) begin
              path_length <= LW'(1); target_index <= '0; path_active <= 1'b1;
            end else if (path_length < LEN_MAX) path_length <= path_length + 1'b1;
          end
          CMD_OBSTACLE: obstacle_flag <= obstacle_in;
          CMD_TICK: begin
            rx <= rx_in; ry <= ry_in; yaw <= yaw_in;
            if (tick_done) begin
              path_active <= 1'b0;
              out_lin <= '0; out_ang <= '0;
              out_rem <= '0; out_kind <= KIND_COMPLETE;
            end else if (tick_stop) begin
              out_lin <= '0; out_ang <= '0;
              out_rem <= 9'(path_length - target_index); out_kind <= KIND_OBSTACLE;
            end
          end
          default: ;
        endcase
      end
      case (state)
        ST_CHECK: begin
          dx <= 33'($signed(xq)) - 33'(rx);
          dy <= 33'($signed(yq)) - 33'(ry);
          rsq <= 42'(mprod);
        end
        ST_SQX: dsq <= 64'(mprod);
        ST_SQY: if (arrived) target_index <= target_index + 1'b1;
        ST_PRE: step_cnt <= '0;
        ST_ITER: step_cnt <= step_cnt + 5'd1;
        ST_WRAP: begin
          if (tgt - 18'(yaw) > PI_Q13) diff <= tgt - 18'(yaw) - TWO_PI_Q13;
          else if (tgt - 18'(yaw) < -PI_Q13) diff <= tgt - 18'(yaw) + TWO_PI_Q13;
          else diff <= tgt - 18'(yaw);
        end
        ST_MUL: prod <= 34'(mprod);
        ST_SAT: begin
          if (sharp) ang_round <= 32'((35'(prod) + 35'sd4096) >>> 13);
          else ang_round <= 32'((35'(prod) + 35'sd8192) >>> 14);
        end
        ST_OUT: begin
          out_lin <= sharp ? 15'd0 : max_linear;
          if (ang_round > 32'($signed({1'b0, max_angular})))
            out_ang <= 16'({1'b0, max_angular});
          else if (ang_round < -32'($signed({1'b0, max_angular})))
            out_ang <= -16'({1'b0, max_angular});
          else out_ang <= 16'(ang_round);
          out_rem <= 9'(path_length - target_index);
          out_kind <= KIND_DRIVE;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {out_rem, out_ang, out_lin};
  assign m_axis_tuser = out_kind;

`include "waypoint_heading_follower_defines.svh"
  `WHF_ASSERT_IMP(a_busy_not_ready, state != ST_IDLE, !s_axis_tready)
  `WHF_ASSERT_IMP(a_len_bound, 1'b1, path_length <= LEN_MAX)
  `WHF_ASSERT_NEXT(a_hold_out, out_valid && !m_axis_tready, out_valid)
endmodule
`default_nettype wire
